// ===== rtl/wfs_pkg.sv =====
// Shared types and constants for the window flatness score block.
// Holds the arithmetic unit request/response structs, result struct and register codes.
// No dependencies.
package wfs_pkg;

  // Field widths
  localparam int ELEV_W     = 16;
  localparam int COORD_IN_W = 8;
  localparam int TOL_W      = 16;
  localparam int RADIUS_W   = 4;
  localparam int GOOD_W     = 10;
  localparam int SCORE_W    = 17;
  localparam int STEP_W     = $clog2(SCORE_W);

  localparam logic [SCORE_W-1:0] SCORE_ONE = 17'h1_0000;

  // Stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b1;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET    = 4'd10;
  localparam logic [TOL_W-1:0]    TOLERANCE_RESET = 16'd300;

  // Shared subtract/compare unit; wide enough for any divider remainder up to MAX_RADIUS 63
  localparam int ALU_W = 18;

  typedef enum logic {
    OP_ABSCMP,
    OP_DIVSTEP
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic [TOL_W-1:0] tol;
  } alu_req_t;

  typedef struct packed {
    logic             flag;
    logic [ALU_W-1:0] res;
  } alu_rsp_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [GOOD_W-1:0]  good_count;
  } wfs_res_t;

endpackage

// ===== rtl/wfs_alu.sv =====
// Shared subtract-and-compare unit: tolerance test on sample differences and
// one restoring division step. Depends on wfs_pkg.
module wfs_alu (
  input  wfs_pkg::alu_req_t req_i,
  output wfs_pkg::alu_rsp_t rsp_o
);
  import wfs_pkg::*;

  logic [ALU_W-1:0] diff;
  logic [ALU_W-1:0] mag;

  always_comb begin
    diff = req_i.a - req_i.b;
    mag  = diff[ALU_W-1] ? (~diff + 1'b1) : diff;
    case (req_i.op)
      OP_ABSCMP: begin
        rsp_o.flag = (mag < ALU_W'(req_i.tol));
        rsp_o.res  = mag;
      end
      OP_DIVSTEP: begin
        // no borrow means the divisor fits: subtract it
        rsp_o.flag = ~diff[ALU_W-1];
        rsp_o.res  = diff[ALU_W-1] ? req_i.a : diff;
      end
      default: begin
        rsp_o.flag = 1'b0;
        rsp_o.res  = '0;
      end
    endcase
  end

endmodule

// ===== rtl/wfs_ctrl.sv =====
// Sequencer for the window flatness score: elevation map memory, window walk,
// good-sample count and serial division. Depends on wfs_pkg; drives wfs_alu.
module wfs_ctrl #(
  parameter int MAP_WIDTH  = 256,
  parameter int MAP_HEIGHT = 256,
  parameter int MAX_RADIUS = 15,
  localparam int RW        = $clog2(MAX_RADIUS + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 req_valid_i,
  output logic                                 req_ready_o,
  input  logic                                 req_mode_i,
  input  logic [wfs_pkg::COORD_IN_W-1:0]       req_x_i,
  input  logic [wfs_pkg::COORD_IN_W-1:0]       req_y_i,
  input  logic [wfs_pkg::ELEV_W-1:0]           req_elev_i,
  input  logic [RW-1:0]                        rad_i,
  input  logic [wfs_pkg::TOL_W-1:0]            tol_i,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output wfs_pkg::wfs_res_t                    res_o,
  output wfs_pkg::alu_req_t                    alu_req_o,
  input  wfs_pkg::alu_rsp_t                    alu_rsp_i
);
  import wfs_pkg::*;

  localparam int XAW      = $clog2(MAP_WIDTH);
  localparam int YAW      = $clog2(MAP_HEIGHT);
  localparam int AW       = $clog2(MAP_WIDTH * MAP_HEIGHT);
  localparam int DEPTH    = MAP_WIDTH * MAP_HEIGHT;
  localparam int OFF_W    = $clog2(2 * MAX_RADIUS + 2);
  localparam int CNT_W    = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int MAPB_W   = (XAW > YAW) ? XAW : YAW;
  localparam int BASE_W   = (MAPB_W > COORD_IN_W) ? MAPB_W : COORD_IN_W;
  localparam int CW       = BASE_W + OFF_W + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CTR   = 3'd1;
  localparam logic [2:0] ST_CLAT  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  function automatic logic [CW-1:0] clamp(input logic [CW-1:0] c, input logic [CW-1:0] lim);
    logic [CW-1:0] r;
    if (c[CW-1]) begin
      r = '0;
    end else if (c > lim) begin
      r = lim;
    end else begin
      r = c;
    end
    return r;
  endfunction

  logic [2:0]              state_q, state_d;
  logic                    smp_vld_q, smp_vld_d;
  logic [COORD_IN_W-1:0]   px_q, px_d, py_q, py_d;
  logic [RW-1:0]           rad_q, rad_d;
  logic [OFF_W-1:0]        span_q, span_d;
  logic [OFF_W-1:0]        ox_q, ox_d, oy_q, oy_d;
  logic [CNT_W-1:0]        area_q, area_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W:0]          rem_q, rem_d;
  logic [SCORE_W-1:0]      quot_q, quot_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [ELEV_W-1:0]       centre_q, centre_d;
  logic [ELEV_W-1:0]       rdata_q;
  logic [ELEV_W-1:0]       mem_q [DEPTH];

  logic [CW-1:0]           cx, cy, cx_cl, cy_cl;
  logic [AW-1:0]           raddr, waddr;
  logic                    wr_en;
  logic [OFF_W-1:0]        side;
  logic [CNT_W+GOOD_W-1:0] good_ext;

  // Window sample address, clamped to the map edges
  always_comb begin
    cx    = CW'(px_q) + CW'(ox_q) - CW'(rad_q);
    cy    = CW'(py_q) + CW'(oy_q) - CW'(rad_q);
    cx_cl = clamp(cx, CW'(MAP_WIDTH - 1));
    cy_cl = clamp(cy, CW'(MAP_HEIGHT - 1));
    raddr = AW'(cy_cl[YAW-1:0]) * AW'(MAP_WIDTH) + AW'(cx_cl[XAW-1:0]);
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign wr_en = req_valid_i && req_ready_o && !req_mode_i
              && (CW'(req_x_i) < CW'(MAP_WIDTH)) && (CW'(req_y_i) < CW'(MAP_HEIGHT));
  assign waddr = AW'(req_y_i) * AW'(MAP_WIDTH) + AW'(req_x_i);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= req_elev_i;
    end
    rdata_q <= mem_q[raddr];
  end

  // Shared unit: tolerance test while scanning, division step afterwards
  always_comb begin
    alu_req_o.tol = tol_i;
    if (state_q == ST_DIV) begin
      alu_req_o.op = OP_DIVSTEP;
      alu_req_o.a  = ALU_W'(rem_q);
      alu_req_o.b  = ALU_W'(area_q);
    end else begin
      alu_req_o.op = OP_ABSCMP;
      alu_req_o.a  = {{(ALU_W - ELEV_W){rdata_q[ELEV_W-1]}}, rdata_q};
      alu_req_o.b  = {{(ALU_W - ELEV_W){centre_q[ELEV_W-1]}}, centre_q};
    end
  end

  assign side = OFF_W'(rad_i) << 1;

  always_comb begin
    state_d   = state_q;
    smp_vld_d = (state_q == ST_SCAN);
    px_d      = px_q;
    py_d      = py_q;
    rad_d     = rad_q;
    span_d    = span_q;
    ox_d      = ox_q;
    oy_d      = oy_q;
    area_d    = area_q;
    count_d   = count_q;
    rem_d     = rem_q;
    quot_d    = quot_q;
    step_d    = step_q;
    centre_d  = centre_q;

    if (smp_vld_q && alu_rsp_i.flag) begin
      count_d = count_q + 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i && req_mode_i) begin
          px_d    = req_x_i;
          py_d    = req_y_i;
          rad_d   = rad_i;
          span_d  = side;
          area_d  = CNT_W'(side + 1'b1) * CNT_W'(side + 1'b1);
          // point at the centre first
          ox_d    = OFF_W'(rad_i);
          oy_d    = OFF_W'(rad_i);
          count_d = '0;
          state_d = ST_CTR;
        end
      end
      ST_CTR: begin
        state_d = ST_CLAT;
      end
      ST_CLAT: begin
        centre_d = rdata_q;
        ox_d     = '0;
        oy_d     = '0;
        state_d  = ST_SCAN;
      end
      ST_SCAN: begin
        if (oy_q == span_q) begin
          oy_d = '0;
          ox_d = ox_q + 1'b1;
          if (ox_q == span_q) begin
            state_d = ST_DRAIN;
          end
        end else begin
          oy_d = oy_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        rem_d   = {1'b0, count_d};
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d  = {alu_rsp_i.res[CNT_W-1:0], 1'b0};
        quot_d = {quot_q[SCORE_W-2:0], alu_rsp_i.flag};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(SCORE_W - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      smp_vld_q <= 1'b0;
      count_q   <= '0;
      step_q    <= '0;
    end else begin
      state_q   <= state_d;
      smp_vld_q <= smp_vld_d;
      count_q   <= count_d;
      step_q    <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q     <= px_d;
    py_q     <= py_d;
    rad_q    <= rad_d;
    span_q   <= span_d;
    ox_q     <= ox_d;
    oy_q     <= oy_d;
    area_q   <= area_d;
    rem_q    <= rem_d;
    quot_q   <= quot_d;
    centre_q <= centre_d;
  end

  assign good_ext          = {{GOOD_W{1'b0}}, count_q};
  assign res_valid_o       = (state_q == ST_EMIT);
  assign res_o.good_count  = good_ext[GOOD_W-1:0];
  assign res_o.score       = quot_q;

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o && req_mode_i) |=> !req_ready_o)
    else $error("request taken while a query is in progress");

  a_count_le_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (count_q <= area_q))
    else $error("good count exceeds window area");

  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.score <= SCORE_ONE))
    else $error("score above one");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(quot_q)))
    else $error("result lost while output stage full");

endmodule

// ===== rtl/window_flatness_score.sv =====
// Window flatness score: keeps an elevation map and scores the flatness of a
// square window around a queried point. A store request writes the map entry
// directly and leaves the block ready. A query request walks the (2R+1)^2 window,
// and the block takes no new request until its result is passed to the output
// register: the walk reads one map sample per cycle through the single map memory
// read port, then the shared subtract unit runs 17 restoring division steps for the
// Q1.16 score. Neighbours beyond the map edge read the nearest edge sample; a map
// entry must be stored before a query reads it. The result waits in an output
// register, so the next request is taken while it is still unread.
// Depends on wfs_pkg, wfs_alu and wfs_ctrl.
module window_flatness_score #(
  parameter int MAP_WIDTH  = 256,
  parameter int MAP_HEIGHT = 256,
  parameter int MAX_RADIUS = 15
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [wfs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // pos_x, pos_y, elevation
  input  logic                               s_axis_tuser,  // mode
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [wfs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // good_count, score, zero pad
  input  logic                               cfg_we_i,
  input  logic [wfs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wfs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import wfs_pkg::*;

  localparam int RW = $clog2(MAX_RADIUS + 1);

  logic [RADIUS_W-1:0] radius_q, radius_d;
  logic [TOL_W-1:0]    tol_q, tol_d;
  logic [RW-1:0]       rad_sat;
  logic                out_vld_q, out_vld_d;
  wfs_res_t            out_q, out_d;
  logic                res_valid, res_ready;
  wfs_res_t            res;
  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;

  always_comb begin
    radius_d = radius_q;
    tol_d    = tol_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RADIUS:    radius_d = cfg_data_i[RADIUS_W-1:0];
        REG_TOLERANCE: tol_d    = cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the radius at the largest window the sequencer supports
  always_comb begin
    if (int'(radius_q) > MAX_RADIUS) begin
      rad_sat = RW'(MAX_RADIUS);
    end else begin
      rad_sat = RW'(radius_q);
    end
  end

  assign res_ready = !out_vld_q || m_axis_tready;

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_vld_d = 1'b1;
      out_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= RADIUS_RESET;
      tol_q     <= TOLERANCE_RESET;
      out_vld_q <= 1'b0;
    end else begin
      radius_q  <= radius_d;
      tol_q     <= tol_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_q.score, out_q.good_count});

  wfs_ctrl #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_HEIGHT (MAP_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_mode_i  (s_axis_tuser),
    .req_x_i     (s_axis_tdata[7:0]),
    .req_y_i     (s_axis_tdata[15:8]),
    .req_elev_i  (s_axis_tdata[31:16]),
    .rad_i       (rad_sat),
    .tol_i       (tol_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp)
  );

  wfs_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for window_flatness_score: stores elevation patches, queries
// windows inside them and compares every score against an in-bench flatness predictor.
// Depends on wfs_pkg and the window_flatness_score RTL.
module testbench;
  import wfs_pkg::*;

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam int MAP_SIDE       = 256;
  localparam int RADIUS_MAX     = 15;
  localparam int SETTLE_CYCLES  = 1000;
  localparam int WATCHDOG_LIMIT = 20000;

  class flatness_scoreboard;
    logic [ELEV_W-1:0] elev_map [MAP_SIDE*MAP_SIDE];
    int unsigned radius;
    int unsigned tolerance;
    wfs_res_t pending_scores[$];
    int unsigned n_errors, n_checked, n_stores, n_queries;

    function new();
      radius    = RADIUS_RESET;
      tolerance = TOLERANCE_RESET;
    endfunction

    function int sample_at(int x, int y);
      int cx, cy;
      cx = (x < 0) ? 0 : (x > MAP_SIDE - 1) ? MAP_SIDE - 1 : x;
      cy = (y < 0) ? 0 : (y > MAP_SIDE - 1) ? MAP_SIDE - 1 : y;
      return int'($signed(elev_map[cy*MAP_SIDE + cx]));
    endfunction

    function wfs_res_t window_flatness(logic [7:0] px, logic [7:0] py);
      wfs_res_t res;
      int r, centre, d;
      int unsigned count, area;
      longint unsigned frac;
      r = (radius > RADIUS_MAX) ? RADIUS_MAX : int'(radius);
      centre = sample_at(px, py);
      count = 0;
      for (int dx = -r; dx <= r; dx++) begin
        for (int dy = -r; dy <= r; dy++) begin
          d = sample_at(int'(px) - dx, int'(py) - dy) - centre;
          if (d < 0) d = -d;
          if (unsigned'(d) < tolerance) count++;
        end
      end
      area = (2*r + 1) * (2*r + 1);
      frac = (longint'(count) << 16) / area;
      res.good_count = count[GOOD_W-1:0];
      res.score      = frac[SCORE_W-1:0];
      return res;
    endfunction

    function void note_request(logic mode, logic [7:0] px, logic [7:0] py,
                               logic [ELEV_W-1:0] elev);
      if (mode == MODE_QUERY) begin
        pending_scores.push_back(window_flatness(px, py));
        n_queries++;
      end else begin
        elev_map[{py, px}] = elev;
        n_stores++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      wfs_res_t got, want;
      got = wfs_res_t'(tdata[$bits(wfs_res_t)-1:0]);
      if (pending_scores.size() == 0) begin
        $error("unexpected result: good_count %0d, score %0d", got.good_count, got.score);
        n_errors++;
        return;
      end
      want = pending_scores.pop_front();
      n_checked++;
      if (got.good_count !== want.good_count) begin
        $error("good_count: expected %0d, got %0d", want.good_count, got.good_count);
        n_errors++;
      end
      if (got.score !== want.score) begin
        $error("score: expected %0d, got %0d", want.score, got.score);
        n_errors++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // pos_x, pos_y, elevation
  logic                   s_axis_tuser;   // mode
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // good_count, score, zero pad
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  flatness_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int n_sent = 0;
  int quiet_cycles = 0;

  window_flatness_score dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_request(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                        s_axis_tdata[31:16]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("window_flatness_score test failed");
      $finish;
    end
  end

  task automatic send_request(input logic mode, input logic [7:0] px, input logic [7:0] py,
                              input logic [ELEV_W-1:0] elev);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {elev, py, px};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  // Hold the sender off until every outstanding query has returned its score.
  task automatic drain_scores();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_scores.size() != 0);
  endtask

  task automatic settle();
    drain_scores();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned radius, input int unsigned tol);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_RADIUS;
    cfg_data_i <= CFG_DATA_W'(radius);
    @(posedge clk_i);
    cfg_idx_i  <= REG_TOLERANCE;
    cfg_data_i <= CFG_DATA_W'(tol);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.radius    = radius;
    sb.tolerance = tol;
  endtask

  // Fill a patch with elevations, then query centres whose whole window lies inside
  // it; clamping at the map edge lets corner patches be narrower than the window.
  task automatic run_episode(input int r, input int tol);
    int side, ox, oy, spread, base, x_lo, x_hi, y_lo, y_hi, n_q;
    logic [ELEV_W-1:0] elev;
    if (r >= 8 || $urandom_range(0, 2) == 0) begin
      side = r + 1 + $urandom_range(0, 3);
      ox = $urandom_range(0, 1) ? 0 : MAP_SIDE - side;
      oy = $urandom_range(0, 1) ? 0 : MAP_SIDE - side;
    end else begin
      side = 2*r + 1 + $urandom_range(0, 3);
      ox = $urandom_range(0, MAP_SIDE - side);
      oy = $urandom_range(0, MAP_SIDE - side);
    end
    case ($urandom_range(0, 4))
      0: spread = 0;
      1: spread = tol / 2;
      2: spread = tol;
      3: spread = 2*tol + 1;
      default: spread = 65535;
    endcase
    base = $urandom_range(0, 65535);
    for (int y = oy; y < oy + side; y++) begin
      for (int x = ox; x < ox + side; x++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(MODE_STORE, 8'($urandom), 8'($urandom), 16'($urandom));
        end
        if ($urandom_range(0, 15) == 0) begin
          elev = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        end else begin
          elev = 16'(base + int'($urandom_range(0, 2*spread)) - spread);
        end
        send_request(MODE_STORE, 8'(x), 8'(y), elev);
      end
    end
    x_lo = (ox == 0) ? 0 : ox + r;
    x_hi = (ox + side == MAP_SIDE) ? MAP_SIDE - 1 : ox + side - 1 - r;
    y_lo = (oy == 0) ? 0 : oy + r;
    y_hi = (oy + side == MAP_SIDE) ? MAP_SIDE - 1 : oy + side - 1 - r;
    n_q = $urandom_range(3, 10);
    repeat (n_q) begin
      send_request(MODE_QUERY, 8'($urandom_range(x_lo, x_hi)), 8'($urandom_range(y_lo, y_hi)),
                   16'($urandom));
    end
    if ($urandom_range(0, 3) == 0) drain_scores();
  endtask

  task automatic run_phase(input int r, input int tol, input int idle_mode, input int items,
                           input bit write_cfg);
    int target;
    if (write_cfg) begin
      settle();
      set_config(r, tol);
    end
    case (idle_mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
      default: begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
    target = n_sent + items;
    while (n_sent < target) run_episode(r, tol);
  endtask

  // Corner cases at radii 1 and 0: edge clamping, full-scale differences and extreme
  // tolerances, including zero tolerance where even the centre does not count.
  task automatic run_directed();
    settle();
    set_config(1, 300);
    send_request(MODE_STORE, 8'd0, 8'd0, 16'sd0);
    send_request(MODE_STORE, 8'd1, 8'd0, 16'sd299);
    send_request(MODE_STORE, 8'd0, 8'd1, -16'sd300);
    send_request(MODE_STORE, 8'd1, 8'd1, 16'sd300);
    send_request(MODE_QUERY, 8'd0, 8'd0, 16'hFFFF);
    send_request(MODE_STORE, 8'd254, 8'd254, 16'h7FFF);
    send_request(MODE_STORE, 8'd255, 8'd254, 16'h8000);
    send_request(MODE_STORE, 8'd254, 8'd255, 16'h8000);
    send_request(MODE_STORE, 8'd255, 8'd255, 16'h7FFF);
    send_request(MODE_QUERY, 8'd255, 8'd255, 16'h0000);
    settle();
    set_config(1, 65535);
    send_request(MODE_QUERY, 8'd255, 8'd255, 16'h0000);
    send_request(MODE_QUERY, 8'd0, 8'd0, 16'h0000);
    settle();
    set_config(0, 0);
    send_request(MODE_QUERY, 8'd0, 8'd0, 16'h0000);
    send_request(MODE_QUERY, 8'd255, 8'd255, 16'h0000);
    settle();
    set_config(0, 1);
    send_request(MODE_QUERY, 8'd0, 8'd0, 16'h0000);
    send_request(MODE_QUERY, 8'd255, 8'd255, 16'h0000);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_STORE;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_RADIUS;
    cfg_data_i    <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values first, before anything is written.
    run_phase(10, 300, 0, 100, 1'b0);
    run_directed();
    run_phase(0, $urandom_range(1, 2000), 1, 80, 1'b1);
    run_phase(2, 300, 2, 100, 1'b1);
    run_phase(3, 65535, 3, 80, 1'b1);
    run_phase(15, 1000, 0, 150, 1'b1);
    run_phase(1, 1, 1, 60, 1'b1);
    run_phase(5, $urandom_range(0, 65535), 3, 50, 1'b1);
    run_phase(7, 0, 2, 60, 1'b1);
    settle();

    $display("Sent %0d requests (%0d stores, %0d queries); %0d scores checked.",
             n_sent, sb.n_stores, sb.n_queries, sb.n_checked);
    $display("Radii 0 to 15, tolerances 0 to 65535, corner clamping, stalls on both sides.");
    if (sb.n_errors == 0) begin
      $display("window_flatness_score test passed");
    end else begin
      $display("window_flatness_score test failed");
    end
    $finish;
  end

endmodule
